// ===== rtl/core/tss_pkg.sv =====
// Package for the tridiagonal system solver core: beat types, state encodings,
// fixed-point constants and the saturating subtract. No dependencies.
package tss_pkg;

    localparam int DW           = 48;
    localparam int IDX_W        = 6;
    localparam int MAX_ROWS_DEF = 64;

    localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] NEG_MAX = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_ONE   = 48'sd16777216;

    typedef struct packed {
        logic signed [DW-1:0] sub_diag;
        logic signed [DW-1:0] main_diag;
        logic signed [DW-1:0] super_diag;
        logic signed [DW-1:0] rhs_value;
        logic                 row_last;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]     row_index;
        logic signed [DW-1:0] solution;
        logic                 singular;
        logic                 result_last;
    } out_beat_t;

    // Operands of one x*y/z request.
    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } md_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] result;
        logic                 zero_div;
    } md_rsp_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_DIV,
        M_FIN,
        M_DONE
    } md_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERD,
        S_E1S,
        S_E1W,
        S_E2S,
        S_E2W,
        S_BRD,
        S_BS1,
        S_BW1,
        S_BS2,
        S_BW2,
        S_ORD,
        S_OUT
    } seq_state_t;

    // a - b, saturated to the 48-bit signed range.
    function automatic logic signed [DW-1:0] sub_sat(logic signed [DW-1:0] a,
                                                     logic signed [DW-1:0] b);
        logic signed [DW:0] diff;
        diff = {a[DW-1], a} - {b[DW-1], b};
        if (diff[DW] != diff[DW-1])
            sub_sat = diff[DW] ? NEG_MAX : POS_MAX;
        else
            sub_sat = diff[DW-1:0];
    endfunction

endpackage

// ===== rtl/core/tss_muldiv.sv =====
// Shared x*y/z unit: 48x48 product from four 24x24 partial products, then a
// restoring division one quotient bit per cycle, or a plain shift when the
// divisor is the Q24.24 unit. Depends on tss_pkg.
module tss_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  tss_pkg::md_req_t req,
    output tss_pkg::md_rsp_t rsp
);

    localparam int DW = tss_pkg::DW;
    localparam int PW = 2 * DW;
    localparam int HW = DW / 2;
    localparam int FW = $clog2(tss_pkg::Q_ONE);

    tss_pkg::md_state_t state_reg, state_next;
    logic [DW-1:0]        ux_reg, ux_next, uy_reg, uy_next, uz_reg, uz_next;
    logic                 neg_reg, neg_next, over_reg, over_next, zdiv_reg, zdiv_next;
    logic                 sh_reg, sh_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [DW-1:0]        rem_reg, rem_next, q_reg, q_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic signed [DW-1:0] res_reg, res_next;

    logic [DW-1:0] mx, my, mz;
    logic [HW-1:0] pa, pb;
    logic [DW-1:0] pp;
    logic [PW-1:0] pp_sh, prod_sum;
    logic [DW:0]   rem_sh;
    logic          ge, neg_xy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        uz_reg   <= uz_next;
        neg_reg  <= neg_next;
        over_reg <= over_next;
        zdiv_reg <= zdiv_next;
        sh_reg   <= sh_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        mx     = req.x[DW-1] ? (~req.x + 1'b1) : req.x;
        my     = req.y[DW-1] ? (~req.y + 1'b1) : req.y;
        mz     = req.z[DW-1] ? (~req.z + 1'b1) : req.z;
        neg_xy = req.x[DW-1] ^ req.y[DW-1];

        pa = cnt_reg[1] ? ux_reg[DW-1:HW] : ux_reg[HW-1:0];
        pb = cnt_reg[0] ? uy_reg[DW-1:HW] : uy_reg[HW-1:0];
        pp = pa * pb;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {{DW{1'b0}}, pp};
            2'd1:    pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
            default: pp_sh = {pp, {DW{1'b0}}};
        endcase
        prod_sum = prod_reg + pp_sh;

        rem_sh = {rem_reg, prod_reg[PW-1]};
        ge     = rem_sh >= {1'b0, uz_reg};

        state_next = state_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        uz_next    = uz_reg;
        neg_next   = neg_reg;
        over_next  = over_reg;
        zdiv_next  = zdiv_reg;
        sh_next    = sh_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        rsp.done     = 1'b0;
        rsp.result   = res_reg;
        rsp.zero_div = zdiv_reg;

        unique case (state_reg)
            tss_pkg::M_IDLE:
            begin
                if (req.start)
                begin
                    ux_next   = mx;
                    uy_next   = my;
                    uz_next   = mz;
                    zdiv_next = 1'b0;
                    if (mx == '0 || my == '0)
                    begin
                        res_next   = '0;
                        zdiv_next  = (mz == '0);
                        state_next = tss_pkg::M_DONE;
                    end
                    else if (mz == '0)
                    begin
                        res_next   = neg_xy ? tss_pkg::NEG_MAX : tss_pkg::POS_MAX;
                        zdiv_next  = 1'b1;
                        state_next = tss_pkg::M_DONE;
                    end
                    else
                    begin
                        neg_next   = neg_xy ^ req.z[DW-1];
                        sh_next    = (mz == tss_pkg::Q_ONE);
                        prod_next  = '0;
                        cnt_next   = '0;
                        state_next = tss_pkg::M_MUL;
                    end
                end
            end
            tss_pkg::M_MUL:
            begin
                prod_next = prod_sum;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    over_next  = 1'b0;
                    state_next = tss_pkg::M_DIV;
                    if (sh_reg)
                    begin
                        // Dividing by the Q24.24 unit only drops the fraction bits.
                        q_next     = prod_sum[DW+FW-1:FW];
                        over_next  = |prod_sum[PW-1:DW+FW];
                        state_next = tss_pkg::M_FIN;
                    end
                end
            end
            tss_pkg::M_DIV:
            begin
                rem_next  = ge ? (rem_sh[DW-1:0] - uz_reg) : rem_sh[DW-1:0];
                q_next    = {q_reg[DW-2:0], ge};
                over_next = over_reg | q_reg[DW-1];
                prod_next = {prod_reg[PW-2:0], 1'b0};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'(PW - 1))
                begin
                    state_next = tss_pkg::M_FIN;
                end
            end
            tss_pkg::M_FIN:
            begin
                if (neg_reg)
                begin
                    if (over_reg || q_reg > {1'b1, {(DW-1){1'b0}}})
                        res_next = tss_pkg::NEG_MAX;
                    else
                        res_next = ~q_reg + 1'b1;
                end
                else
                begin
                    if (over_reg || q_reg[DW-1])
                        res_next = tss_pkg::POS_MAX;
                    else
                        res_next = q_reg;
                end
                state_next = tss_pkg::M_DONE;
            end
            tss_pkg::M_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = tss_pkg::M_IDLE;
            end
            default:
            begin
                state_next = tss_pkg::M_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tridiagonal_system_solver_core.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, Q24.24).
// Depends on tss_pkg and tss_muldiv.
//
//  Channel | Signals                      | Beat
//  --------+------------------------------+-------------------------------------
//  in      | in_valid, in_ready, in_data  | one row: sub, main, super, rhs, last
//  out     | out_valid, out_ready, out_data| one unknown with its row index
//
// Every x*y/z runs through the single shared multiply-divide unit: partial
// products first, then restoring division, then the hand-over. The c*x
// products of back substitution divide by the Q24.24 unit and take a shift
// instead. Row 0 is stored on acceptance; every later row needs two divisions
// before the input is ready again. The row marked last then starts back
// substitution, one division for the last row and a product and a division
// for each other row, after which the unknowns are sent from the last row
// down. Reset is asynchronous and clears only control state; the coefficient
// memories hold nothing useful until written. The input is not ready while a
// row or a solve is being worked on; a stall on the output merely holds the
// sequencer in its emit state.
module tridiagonal_system_solver_core #(
    parameter int MAX_ROWS = tss_pkg::MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tss_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tss_pkg::out_beat_t out_data
);

    localparam int DW = tss_pkg::DW;
    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    tss_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          sing_reg, sing_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          first_reg, first_next;

    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic                 last_reg;
    logic signed [DW-1:0] t1_reg, t1_next, u_reg, u_next, x_reg, x_next;

    tss_pkg::out_beat_t out_reg, out_next;
    logic               ovalid_reg, ovalid_next;

    // Coefficient and solution memories, one write and one read port each.
    logic signed [DW-1:0] piv_mem [MAX_ROWS];
    logic signed [DW-1:0] rhs_mem [MAX_ROWS];
    logic signed [DW-1:0] upr_mem [MAX_ROWS];
    logic signed [DW-1:0] sol_mem [MAX_ROWS];
    logic signed [DW-1:0] piv_q, rhs_q, upr_q, sol_q;

    logic                 coef_we, sol_we;
    logic [IW-1:0]        wr_addr, rd_addr, count_m1;
    logic signed [DW-1:0] piv_wd, rhs_wd;

    tss_pkg::md_req_t md_req;
    tss_pkg::md_rsp_t md_rsp;
    logic             in_fire;

    tss_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign in_fire   = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
    assign count_m1  = IW'(count_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tss_pkg::S_IDLE;
            count_reg  <= '0;
            sing_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sing_reg   <= sing_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg    <= in_data.sub_diag;
            b_reg    <= in_data.main_diag;
            c_reg    <= in_data.super_diag;
            d_reg    <= in_data.rhs_value;
            last_reg <= in_data.row_last;
        end
        idx_reg   <= idx_next;
        first_reg <= first_next;
        t1_reg    <= t1_next;
        u_reg     <= u_next;
        x_reg     <= x_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            piv_mem[wr_addr] <= piv_wd;
            rhs_mem[wr_addr] <= rhs_wd;
            upr_mem[wr_addr] <= (state_reg == tss_pkg::S_IDLE) ? in_data.super_diag
                                                                : c_reg;
        end
        if (sol_we)
        begin
            sol_mem[idx_reg] <= md_rsp.result;
        end
        piv_q <= piv_mem[rd_addr];
        rhs_q <= rhs_mem[rd_addr];
        upr_q <= upr_mem[rd_addr];
        sol_q <= sol_mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sing_next   = sing_reg | (md_rsp.done & md_rsp.zero_div);
        idx_next    = idx_reg;
        first_next  = first_reg;
        t1_next     = t1_reg;
        u_next      = u_reg;
        x_next      = x_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !out_ready;
        in_ready    = 1'b0;
        coef_we     = 1'b0;
        sol_we      = 1'b0;
        wr_addr     = count_reg[IW-1:0];
        piv_wd      = tss_pkg::sub_sat(b_reg, t1_reg);
        rhs_wd      = tss_pkg::sub_sat(d_reg, md_rsp.result);
        md_req      = '{start: 1'b0, x: upr_q, y: a_reg, z: piv_q};
        rd_addr     = idx_reg;

        unique case (state_reg)
            tss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = count_m1;
                if (in_fire)
                begin
                    if (count_reg >= CW'(MAX_ROWS))
                    begin
                        // Rows beyond capacity are dropped; their last mark still counts.
                        if (in_data.row_last)
                        begin
                            idx_next   = count_m1;
                            first_next = 1'b1;
                            state_next = tss_pkg::S_BRD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        coef_we    = 1'b1;
                        piv_wd     = in_data.main_diag;
                        rhs_wd     = in_data.rhs_value;
                        count_next = count_reg + 1'b1;
                        if (in_data.row_last)
                        begin
                            idx_next   = '0;
                            first_next = 1'b1;
                            state_next = tss_pkg::S_BRD;
                        end
                    end
                    else
                    begin
                        state_next = tss_pkg::S_ERD;
                    end
                end
            end
            tss_pkg::S_ERD:
            begin
                rd_addr    = count_m1;
                state_next = tss_pkg::S_E1S;
            end
            tss_pkg::S_E1S:
            begin
                rd_addr      = count_m1;
                md_req.start = 1'b1;
                state_next   = tss_pkg::S_E1W;
            end
            tss_pkg::S_E1W:
            begin
                rd_addr = count_m1;
                if (md_rsp.done)
                begin
                    t1_next    = md_rsp.result;
                    state_next = tss_pkg::S_E2S;
                end
            end
            tss_pkg::S_E2S:
            begin
                rd_addr      = count_m1;
                md_req.x     = rhs_q;
                md_req.start = 1'b1;
                state_next   = tss_pkg::S_E2W;
            end
            tss_pkg::S_E2W:
            begin
                rd_addr = count_m1;
                if (md_rsp.done)
                begin
                    coef_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (last_reg)
                    begin
                        idx_next   = count_reg[IW-1:0];
                        first_next = 1'b1;
                        state_next = tss_pkg::S_BRD;
                    end
                    else
                    begin
                        state_next = tss_pkg::S_IDLE;
                    end
                end
            end
            tss_pkg::S_BRD:
            begin
                state_next = tss_pkg::S_BS1;
            end
            tss_pkg::S_BS1:
            begin
                md_req.start = 1'b1;
                if (first_reg)
                begin
                    md_req.x   = rhs_q;
                    md_req.y   = tss_pkg::Q_ONE;
                    md_req.z   = piv_q;
                    state_next = tss_pkg::S_BW2;
                end
                else
                begin
                    md_req.x   = upr_q;
                    md_req.y   = x_reg;
                    md_req.z   = tss_pkg::Q_ONE;
                    state_next = tss_pkg::S_BW1;
                end
            end
            tss_pkg::S_BW1:
            begin
                if (md_rsp.done)
                begin
                    u_next     = tss_pkg::sub_sat(rhs_q, md_rsp.result);
                    state_next = tss_pkg::S_BS2;
                end
            end
            tss_pkg::S_BS2:
            begin
                md_req.start = 1'b1;
                md_req.x     = u_reg;
                md_req.y     = tss_pkg::Q_ONE;
                md_req.z     = piv_q;
                state_next   = tss_pkg::S_BW2;
            end
            tss_pkg::S_BW2:
            begin
                if (md_rsp.done)
                begin
                    x_next     = md_rsp.result;
                    sol_we     = 1'b1;
                    first_next = 1'b0;
                    if (idx_reg == '0)
                    begin
                        idx_next   = count_m1;
                        state_next = tss_pkg::S_ORD;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = tss_pkg::S_BRD;
                    end
                end
            end
            tss_pkg::S_ORD:
            begin
                state_next = tss_pkg::S_OUT;
            end
            tss_pkg::S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next          = 1'b1;
                    out_next.row_index   = tss_pkg::IDX_W'(idx_reg);
                    out_next.solution    = sol_q;
                    out_next.singular    = sing_reg;
                    out_next.result_last = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        count_next = '0;
                        sing_next  = 1'b0;
                        state_next = tss_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = tss_pkg::S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = tss_pkg::S_IDLE;
            end
        endcase
    end

    // The stored row count never passes the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ROWS))
        else $error("row count beyond memory depth");

    // The shared unit only reports completion while the sequencer waits for it.
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == tss_pkg::S_E1W || state_reg == tss_pkg::S_E2W ||
                         state_reg == tss_pkg::S_BW1 || state_reg == tss_pkg::S_BW2))
        else $error("multiply-divide result with no waiting state");

    // The beat for row 0 ends a solve: the next cycle starts clean.
    a_solve_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tss_pkg::S_OUT && state_next == tss_pkg::S_IDLE)
        |=> (count_reg == '0 && !sing_reg && out_data.result_last))
        else $error("solve did not finish cleanly");

endmodule
